// ===== sv/axis_rainbow_colorizer_core_defines.svh =====
// Assertion macros shared by the rainbow colouriser RTL.
`ifndef AXIS_RAINBOW_COLORIZER_CORE_DEFINES_SVH
`define AXIS_RAINBOW_COLORIZER_CORE_DEFINES_SVH

// Checks in the same cycle that the consequent holds whenever the antecedent holds.
`define ARC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks in the next cycle that the consequent holds after the antecedent held.
`define ARC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/arc_pkg.sv =====
// Constants shared by the rainbow colouriser: widths, register indexes and resets, axis and sector codes.
package arc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_INDEX_W     = 2;
    localparam int LEVEL_W         = 8;
    localparam int SECTOR_W        = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_SELECT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_MINIMUM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_MAXIMUM = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] AXIS_SELECT_RESET  = AXIS_Z;
    localparam int         AXIS_MINIMUM_RESET = 0;
    localparam int         AXIS_MAXIMUM_RESET = 65536;

    localparam logic [SECTOR_W-1:0] SECTOR_RED    = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YELLOW = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN  = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYAN   = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE   = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

endpackage

// ===== sv/axis_rainbow_colorizer_core.sv =====
// Rainbow colouriser: maps one coordinate of a 3-D point to an RGB colour.
//
// The s_ channel carries one point per item, coordinates x, y and z packed from
// the lowest bit up. The m_ channel returns red, green and blue levels in tdata
// and a clamp flag in tuser. The cfg_ channel writes the axis select, minimum
// and maximum registers; it is always ready and should be written while idle.
//
// The datapath is a 14-stage pipeline: operand setup, sign fix and clamp,
// sector multiples, sector compare, ramp scaling, eight stages that each
// resolve one quotient bit of the ramp level, and the output register.
// One item is accepted every cycle while the receiver does not stall, and the
// one-bit-per-stage ramp division sets the depth of the pipeline.
//
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver fills the empty stages first
// and only then lowers s_tready; nothing is dropped or repeated.
// Reset empties the pipeline and restores the register defaults.
`include "axis_rainbow_colorizer_core_defines.svh"

module axis_rainbow_colorizer_core #(
    parameter int COORD_WIDTH = arc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // coord_x, coord_y, coord_z, then zero padding to whole bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // red_level, green_level, blue_level
    output logic [3*arc_pkg::LEVEL_W-1:0]       m_tdata,
    // was_clamped
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int NW   = W + 1;
    localparam int XW   = W + arc_pkg::LEVEL_W;
    localparam int QW   = arc_pkg::LEVEL_W;
    localparam int SW   = arc_pkg::SECTOR_W;
    localparam int NS   = 6 + QW;

    typedef struct packed {
        logic signed [NW-1:0] n;
        logic signed [NW-1:0] d;
    } st1_t;

    typedef struct packed {
        logic [W-1:0] un;
        logic [W-1:0] ud;
        logic         zero;
        logic         clamped;
    } st2_t;

    typedef struct packed {
        logic [W+1:0] four_un;
        logic [W-1:0] ud;
        logic [W+1:0] ud3;
        logic         zero;
        logic         clamped;
    } st3_t;

    typedef struct packed {
        logic [SW-1:0] sector;
        logic [W-1:0]  rem;
        logic [W-1:0]  ud;
        logic          zero;
        logic          clamped;
    } st4_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [W-1:0]  ud;
        logic [QW-1:0] q;
        logic [SW-1:0] sector;
        logic          zero;
        logic          clamped;
    } div_t;

    logic [1:0]   axis_sel_reg;
    logic [W-1:0] axis_min_reg;
    logic [W-1:0] axis_max_reg;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    div_t div_reg  [QW+1];
    div_t div_next [QW+1];

    logic [3*arc_pkg::LEVEL_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_sel_reg <= arc_pkg::AXIS_SELECT_RESET;
            axis_min_reg <= W'(arc_pkg::AXIS_MINIMUM_RESET);
            axis_max_reg <= W'(arc_pkg::AXIS_MAXIMUM_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                arc_pkg::REG_AXIS_SELECT:  axis_sel_reg <= cfg_data[1:0];
                arc_pkg::REG_AXIS_MINIMUM: axis_min_reg <= cfg_data;
                arc_pkg::REG_AXIS_MAXIMUM: axis_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NS; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Stage 1: pick the coordinate and form offset and span.
    always_comb begin
        logic [W-1:0] v;
        unique case (axis_sel_reg)
            arc_pkg::AXIS_X: v = s_tdata[W-1:0];
            arc_pkg::AXIS_Y: v = s_tdata[2*W-1:W];
            default:         v = s_tdata[3*W-1:2*W];
        endcase
        st1_next.n = $signed({v[W-1], v}) - $signed({axis_min_reg[W-1], axis_min_reg});
        st1_next.d = $signed({axis_max_reg[W-1], axis_max_reg})
                   - $signed({axis_min_reg[W-1], axis_min_reg});
    end

    // Stage 2: make the span positive and clamp the offset into it.
    always_comb begin
        logic signed [NW-1:0] nn;
        logic signed [NW-1:0] dd;
        nn = st1_reg.d[NW-1] ? -st1_reg.n : st1_reg.n;
        dd = st1_reg.d[NW-1] ? -st1_reg.d : st1_reg.d;
        st2_next.ud   = dd[W-1:0];
        st2_next.zero = (st1_reg.d == '0);
        if (nn[NW-1] || nn == '0) begin
            st2_next.un      = '0;
            st2_next.clamped = nn[NW-1];
        end else if (nn >= dd) begin
            st2_next.un      = dd[W-1:0];
            st2_next.clamped = (nn != dd);
        end else begin
            st2_next.un      = nn[W-1:0];
            st2_next.clamped = 1'b0;
        end
        if (st2_next.zero) begin
            st2_next.clamped = 1'b1;
        end
    end

    // Stage 3: multiples of the span for the sector search.
    always_comb begin
        st3_next.four_un = {st2_reg.un, 2'b00};
        st3_next.ud      = st2_reg.ud;
        st3_next.ud3     = {2'b00, st2_reg.ud} + {1'b0, st2_reg.ud, 1'b0};
        st3_next.zero    = st2_reg.zero;
        st3_next.clamped = st2_reg.clamped;
    end

    // Stage 4: sector index and the remainder within the sector.
    always_comb begin
        logic [W+1:0] m1;
        logic [W+1:0] m2;
        logic [W+1:0] m4;
        logic [W+1:0] sub;
        m1 = {2'b00, st3_reg.ud};
        m2 = {1'b0, st3_reg.ud, 1'b0};
        m4 = {st3_reg.ud, 2'b00};
        priority if (st3_reg.four_un >= m4) begin
            st4_next.sector = arc_pkg::SECTOR_BLUE;
            sub             = m4;
        end else if (st3_reg.four_un >= st3_reg.ud3) begin
            st4_next.sector = arc_pkg::SECTOR_CYAN;
            sub             = st3_reg.ud3;
        end else if (st3_reg.four_un >= m2) begin
            st4_next.sector = arc_pkg::SECTOR_GREEN;
            sub             = m2;
        end else if (st3_reg.four_un >= m1) begin
            st4_next.sector = arc_pkg::SECTOR_YELLOW;
            sub             = m1;
        end else begin
            st4_next.sector = arc_pkg::SECTOR_RED;
            sub             = '0;
        end
        st4_next.rem     = W'(st3_reg.four_un - sub);
        st4_next.ud      = st3_reg.ud;
        st4_next.zero    = st3_reg.zero;
        st4_next.clamped = st3_reg.clamped;
    end

    // Stage 5: scale the remainder by 255 ahead of the ramp division.
    always_comb begin
        div_next[0].x       = {st4_reg.rem, {QW{1'b0}}} - {{QW{1'b0}}, st4_reg.rem};
        div_next[0].ud      = st4_reg.ud;
        div_next[0].q       = '0;
        div_next[0].sector  = st4_reg.sector;
        div_next[0].zero    = st4_reg.zero;
        div_next[0].clamped = st4_reg.clamped;
    end

    // Ramp division: one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int K = QW - 1 - j;
        always_comb begin
            logic [XW:0] cand;
            cand = {1'b0, div_reg[j].x} - ({{(XW + 1 - W){1'b0}}, div_reg[j].ud} << K);
            div_next[j+1] = div_reg[j];
            if (!cand[XW]) begin
                div_next[j+1].x    = cand[XW-1:0];
                div_next[j+1].q[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[5+j]) begin
                div_reg[j+1] <= div_next[j+1];
            end
        end
    end

    // Output stage: rising and falling ramps and the sector colour.
    always_comb begin
        logic [QW-1:0] rise;
        logic [QW-1:0] fall;
        logic [QW-1:0] r8;
        logic [QW-1:0] g8;
        logic [QW-1:0] b8;
        rise = div_reg[QW].q;
        fall = arc_pkg::LEVEL_FULL - rise - {{(QW-1){1'b0}}, (div_reg[QW].x != '0)};
        unique case (div_reg[QW].sector)
            arc_pkg::SECTOR_RED: begin
                r8 = arc_pkg::LEVEL_FULL; g8 = rise; b8 = '0;
            end
            arc_pkg::SECTOR_YELLOW: begin
                r8 = fall; g8 = arc_pkg::LEVEL_FULL; b8 = '0;
            end
            arc_pkg::SECTOR_GREEN: begin
                r8 = '0; g8 = arc_pkg::LEVEL_FULL; b8 = rise;
            end
            arc_pkg::SECTOR_CYAN: begin
                r8 = '0; g8 = fall; b8 = arc_pkg::LEVEL_FULL;
            end
            default: begin
                r8 = '0; g8 = '0; b8 = arc_pkg::LEVEL_FULL;
            end
        endcase
        if (div_reg[QW].zero) begin
            r8 = arc_pkg::LEVEL_FULL;
            g8 = '0;
            b8 = '0;
        end
        m_tdata_next = {b8, g8, r8};
        m_tuser_next = div_reg[QW].clamped;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            st1_reg <= st1_next;
        end
        if (en[1]) begin
            st2_reg <= st2_next;
        end
        if (en[2]) begin
            st3_reg <= st3_next;
        end
        if (en[3]) begin
            st4_reg <= st4_next;
        end
        if (en[4]) begin
            div_reg[0] <= div_next[0];
        end
        if (en[NS-1]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    `ARC_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[0],
        "accepted item did not enter the first stage")

    `ARC_ASSERT_IMP(a_rem_in_sector, aclk, aresetn, vld_reg[3] && !st4_reg.zero,
        (st4_reg.rem < st4_reg.ud) ||
        (st4_reg.sector == arc_pkg::SECTOR_BLUE && st4_reg.rem == '0),
        "sector remainder not below the span")

    `ARC_ASSERT_IMP(a_one_full, aclk, aresetn, m_tvalid,
        m_tdata[7:0] == arc_pkg::LEVEL_FULL || m_tdata[15:8] == arc_pkg::LEVEL_FULL ||
        m_tdata[23:16] == arc_pkg::LEVEL_FULL,
        "rainbow colour has no channel at full level")

    `ARC_ASSERT_IMP(a_one_off, aclk, aresetn, m_tvalid,
        m_tdata[7:0] == '0 || m_tdata[15:8] == '0 || m_tdata[23:16] == '0,
        "rainbow colour has no channel switched off")

endmodule
